// ===== rtl/wdd_pkg.sv =====
// wind display driver package: field widths, register indexes, reset values,
// reciprocal constants and the rose sector mask function
// no dependencies
package wdd_pkg;

    localparam int unsigned GROUP_W    = 17;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 17;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GROUP   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TENTHS  = 4'd3;

    // register reset values
    localparam logic [GROUP_W-1:0] RST_GROUP   = 17'd130306;
    localparam logic [7:0]         RST_TIMEOUT = 8'd5;
    localparam logic [7:0]         RST_TICKS   = 8'd25;
    localparam logic [3:0]         RST_TENTHS  = 4'd10;

    // format bytes above this one carry a group extension
    localparam logic [7:0] PF_GROUP_MIN = 8'd239;

    // east plus south
    localparam logic [7:0] NODATA_PATTERN = 8'h14;

    // speed: level = floor(speed * 2550 / 24693); saturates from 2479 upwards
    localparam logic [11:0] SPEED_SAT   = 12'd2479;
    localparam logic [24:0] SPEED_RECIP = 25'd27720829;   // ceil(2^28 * 2550 / 24693)
    localparam int unsigned SPEED_SHIFT = 28;

    // angle: sector = floor((160 * angle + 314159) / 628318) mod 16
    localparam logic [23:0] ANGLE_OFFSET = 24'd314159;
    localparam logic [24:0] ANGLE_RECIP  = 25'd27998858;  // ceil(2^44 / 628318)
    localparam int unsigned ANGLE_SHIFT  = 44;

    typedef struct packed {
        logic [GROUP_W-1:0] group_number;
        logic [7:0]         timeout_seconds;
        logic [7:0]         ticks_per_tenth;
        logic [3:0]         tenths_per_second;
    } t_cfg;

    typedef struct packed {
        logic        cmd;
        logic        data_page;
        logic [7:0]  pdu_format;
        logic [7:0]  pdu_specific;
        logic [15:0] wind_speed;
        logic [15:0] wind_angle;
    } t_in_item;

    typedef struct packed {
        logic       hit;
        logic [7:0] level;
        logic [7:0] mask;
    } t_frame_res;

    typedef struct packed {
        logic step;
        logic tick;
        logic frame_hit;
    } t_tb_ctl;

    // even sector lights one led, odd sector lights the two neighbours
    function automatic logic [7:0] sector_mask(input logic [3:0] sector);
        logic [2:0] lo;
        logic [2:0] hi;
        logic [7:0] m;
        lo = sector[3:1];
        hi = lo + 3'd1;
        m  = 8'd1 << lo;
        if (sector[0]) begin
            m = m | (8'd1 << hi);
        end
        return m;
    endfunction

endpackage

// ===== rtl/wdd_in_if.sv =====
// input channel of the wind display driver: frames and timer ticks
// depends on nothing
interface wdd_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic        data_page;
    logic [7:0]  pdu_format;
    logic [7:0]  pdu_specific;
    logic [15:0] wind_speed;
    logic [15:0] wind_angle;

    modport source (
        output valid, cmd, data_page, pdu_format, pdu_specific, wind_speed, wind_angle,
        input  ready
    );
    modport sink (
        input  valid, cmd, data_page, pdu_format, pdu_specific, wind_speed, wind_angle,
        output ready
    );
endinterface

// ===== rtl/wdd_out_if.sv =====
// output channel of the wind display driver: led and dac state per transaction
// depends on nothing
interface wdd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] led_on;
    logic       led_update;
    logic [7:0] dac_level;
    logic       dac_update;

    modport source (
        output valid, led_on, led_update, dac_level, dac_update,
        input  ready
    );
    modport sink (
        input  valid, led_on, led_update, dac_level, dac_update,
        output ready
    );
endinterface

// ===== rtl/wind_display_driver.sv =====
// wind display driver top level: input register, frame and tick processing,
// result register; depends on wdd_pkg, wdd_in_if and wdd_out_if
// an accepted input transaction passes the input register, then the result register;
// throughput one transaction per cycle, ready passed back from the output
// synchronous active-low reset restores the register defaults, reloads the
// dividers and timeout, darkens all leds and sets the dac level to zero
module wind_display_driver (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wdd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wdd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    wdd_in_if.sink                           i_in,
    wdd_out_if.source                        o_out
);
    import wdd_pkg::*;

    t_cfg       r_cfg;
    t_in_item   r_in;
    logic       r_in_vld;
    logic       r_out_vld;
    logic       r_out_upd;
    logic [7:0] r_led, n_led;
    logic [7:0] r_dac, n_dac;
    logic       n_upd;
    logic       advance;
    logic       in_take;
    logic       nodata;
    t_frame_res frame_res;
    t_tb_ctl    tb_ctl;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.group_number      <= RST_GROUP;
            r_cfg.timeout_seconds   <= RST_TIMEOUT;
            r_cfg.ticks_per_tenth   <= RST_TICKS;
            r_cfg.tenths_per_second <= RST_TENTHS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GROUP:   r_cfg.group_number      <= i_cfg_data[GROUP_W-1:0];
                REG_TIMEOUT: r_cfg.timeout_seconds   <= i_cfg_data[7:0];
                REG_TICKS:   r_cfg.ticks_per_tenth   <= i_cfg_data[7:0];
                REG_TENTHS:  r_cfg.tenths_per_second <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // pipeline handshake
    assign advance    = !r_out_vld || o_out.ready;
    assign i_in.ready = !r_in_vld || advance;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.cmd          <= i_in.cmd;
            r_in.data_page    <= i_in.data_page;
            r_in.pdu_format   <= i_in.pdu_format;
            r_in.pdu_specific <= i_in.pdu_specific;
            r_in.wind_speed   <= i_in.wind_speed;
            r_in.wind_angle   <= i_in.wind_angle;
        end
    end

    wdd_frame_calc u_frame_calc (
        .i_item         (r_in),
        .i_group_number (r_cfg.group_number),
        .o_res          (frame_res)
    );

    assign tb_ctl.step      = r_in_vld && advance;
    assign tb_ctl.tick      = r_in.cmd;
    assign tb_ctl.frame_hit = frame_res.hit;

    wdd_timebase u_timebase (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_ctl   (tb_ctl),
        .o_nodata(nodata)
    );

    // led and dac state, held between transactions
    always_comb begin
        n_led = r_led;
        n_dac = r_dac;
        n_upd = 1'b0;
        if (tb_ctl.step && frame_res.hit) begin
            n_led = frame_res.mask;
            n_dac = frame_res.level;
            n_upd = 1'b1;
        end else if (nodata) begin
            n_led = NODATA_PATTERN;
            n_dac = 8'd0;
            n_upd = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led     <= 8'd0;
            r_dac     <= 8'd0;
            r_out_upd <= 1'b0;
        end else if (tb_ctl.step) begin
            r_led     <= n_led;
            r_dac     <= n_dac;
            r_out_upd <= n_upd;
        end
    end

    // result register drives the output channel
    assign o_out.valid      = r_out_vld;
    assign o_out.led_on     = r_led;
    assign o_out.led_update = r_out_upd;
    assign o_out.dac_level  = r_dac;
    assign o_out.dac_update = r_out_upd;

endmodule

// ===== rtl/wdd_frame_calc.sv =====
// frame decode: group number match, speed to dac level, angle to led mask
// depends on wdd_pkg
module wdd_frame_calc (
    input  wdd_pkg::t_in_item            i_item,
    input  logic [wdd_pkg::GROUP_W-1:0]  i_group_number,
    output wdd_pkg::t_frame_res          o_res
);
    import wdd_pkg::*;

    logic [GROUP_W-1:0] group;
    logic [36:0]        speed_prod;
    logic [23:0]        angle_num;
    logic [48:0]        angle_prod;
    logic [3:0]         sector;

    // group number, extension only counts for group formats
    always_comb begin
        group = {i_item.data_page, i_item.pdu_format, 8'h00};
        if (i_item.pdu_format > PF_GROUP_MIN) begin
            group[7:0] = i_item.pdu_specific;
        end
    end

    // speed level by reciprocal multiply, saturated
    assign speed_prod = {25'd0, i_item.wind_speed[11:0]} * {12'd0, SPEED_RECIP};

    // sector by reciprocal multiply of the halved numerator
    assign angle_num  = ({8'd0, i_item.wind_angle} << 7) + ({8'd0, i_item.wind_angle} << 5)
                        + ANGLE_OFFSET;
    assign angle_prod = {25'd0, angle_num} * {24'd0, ANGLE_RECIP};
    assign sector     = angle_prod[ANGLE_SHIFT+3:ANGLE_SHIFT];

    always_comb begin
        o_res.hit  = (i_item.cmd == 1'b0) && (group == i_group_number);
        o_res.mask = sector_mask(sector);
        if (i_item.wind_speed >= {4'd0, SPEED_SAT}) begin
            o_res.level = 8'hff;
        end else begin
            o_res.level = speed_prod[SPEED_SHIFT+7:SPEED_SHIFT];
        end
    end

endmodule

// ===== rtl/wdd_timebase.sv =====
// tick dividers and frame timeout; flags the no-data second
// depends on wdd_pkg
module wdd_timebase (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  wdd_pkg::t_cfg    i_cfg,
    input  wdd_pkg::t_tb_ctl i_ctl,
    output logic             o_nodata
);
    import wdd_pkg::*;

    logic [7:0] r_tick_div, n_tick_div;
    logic [3:0] r_tenth_div, n_tenth_div;
    logic [7:0] r_timeout, n_timeout;

    // divider chain and timeout countdown
    always_comb begin
        n_tick_div  = r_tick_div;
        n_tenth_div = r_tenth_div;
        n_timeout   = r_timeout;
        o_nodata    = 1'b0;
        if (i_ctl.step && i_ctl.tick) begin
            if (r_tick_div <= 8'd1) begin
                n_tick_div = i_cfg.ticks_per_tenth;
                if (r_tenth_div <= 4'd1) begin
                    n_tenth_div = i_cfg.tenths_per_second;
                    if (r_timeout == 8'd0) begin
                        o_nodata = 1'b1;
                    end else begin
                        n_timeout = r_timeout - 8'd1;
                    end
                end else begin
                    n_tenth_div = r_tenth_div - 4'd1;
                end
            end else begin
                n_tick_div = r_tick_div - 8'd1;
            end
        end else if (i_ctl.step && i_ctl.frame_hit) begin
            n_timeout = i_cfg.timeout_seconds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_div  <= RST_TICKS;
            r_tenth_div <= RST_TENTHS;
            r_timeout   <= RST_TIMEOUT;
        end else begin
            r_tick_div  <= n_tick_div;
            r_tenth_div <= n_tenth_div;
            r_timeout   <= n_timeout;
        end
    end

endmodule

// ===== tb/wdd_tb_pkg.sv =====
// testbench types for the wind display driver: transaction kind codes and the
// record of one display result as it leaves the block
// no dependencies
package wdd_tb_pkg;

    // kind of an input transaction
    typedef enum logic {
        CMD_FRAME = 1'b0,
        CMD_TICK  = 1'b1
    } t_cmd;

    // led and dac state carried by one output transaction
    typedef struct packed {
        logic [7:0] led_on;
        logic       led_update;
        logic [7:0] dac_level;
        logic       dac_update;
    } t_display;

endpackage

// ===== tb/wind_display_driver_checker.sv =====
// checker for the wind display driver: watches the config port and both channels,
// predicts the display state of every accepted input and compares it in order
// depends on wdd_pkg, wdd_tb_pkg, wdd_in_if and wdd_out_if
module wind_display_driver_checker
    import wdd_pkg::*;
    import wdd_tb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    wdd_in_if                     i_in_mon,
    wdd_out_if                    i_out_mon,
    output int unsigned           o_mismatch_total,
    output int unsigned           o_pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow registers
    logic [GROUP_W-1:0] cfg_group;
    logic [7:0]         cfg_timeout;
    logic [7:0]         cfg_ticks;
    logic [3:0]         cfg_tenths;

    // predicted block state
    logic [7:0] tick_count;
    logic [3:0] tenth_count;
    logic [7:0] seconds_left;
    logic [7:0] led_shown;
    logic [7:0] dac_shown;

    t_display    display_q[$];
    int unsigned mismatches = 0;
    t_in_item    seen_item;
    t_display    seen_display;
    t_display    want_display;

    // works out the display state after one frame or tick
    function automatic t_display predict_display(input t_in_item item);
        logic [GROUP_W-1:0] group;
        int unsigned        level;
        int unsigned        sector;
        logic [2:0]         lo;
        logic [7:0]         mask;
        t_display           res;
        res.led_update = 1'b0;
        res.dac_update = 1'b0;
        if (item.cmd == CMD_FRAME) begin
            group = {item.data_page, item.pdu_format, 8'h00};
            if (item.pdu_format > PF_GROUP_MIN) begin
                group[7:0] = item.pdu_specific;
            end
            if (group == cfg_group) begin
                level  = (int'(item.wind_speed) * 2550) / 24693;
                sector = ((int'(item.wind_angle) * 320 + 628318) / 1256636) % 16;
                // one led on even sectors, the neighbour above it too on odd ones
                lo   = sector[3:1];
                mask = 8'd1 << lo;
                if (sector[0]) begin
                    mask = mask | {mask[6:0], mask[7]};
                end
                seconds_left   = cfg_timeout;
                dac_shown      = (level > 255) ? 8'hFF : level[7:0];
                led_shown      = mask;
                res.led_update = 1'b1;
                res.dac_update = 1'b1;
            end
        end else begin
            // tick divider, then tenth divider, then the one-second timeout step
            if (tick_count <= 8'd1) begin
                tick_count = cfg_ticks;
                if (tenth_count <= 4'd1) begin
                    tenth_count = cfg_tenths;
                    if (seconds_left == 8'd0) begin
                        led_shown      = NODATA_PATTERN;
                        dac_shown      = 8'd0;
                        res.led_update = 1'b1;
                        res.dac_update = 1'b1;
                    end else begin
                        seconds_left = seconds_left - 8'd1;
                    end
                end else begin
                    tenth_count = tenth_count - 4'd1;
                end
            end else begin
                tick_count = tick_count - 8'd1;
            end
        end
        res.led_on    = led_shown;
        res.dac_level = dac_shown;
        return res;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // per-edge bookkeeping: results first, then the new input, then config
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_group    = RST_GROUP;
            cfg_timeout  = RST_TIMEOUT;
            cfg_ticks    = RST_TICKS;
            cfg_tenths   = RST_TENTHS;
            tick_count   = RST_TICKS;
            tenth_count  = RST_TENTHS;
            seconds_left = RST_TIMEOUT;
            led_shown    = 8'd0;
            dac_shown    = 8'd0;
            display_q.delete();
        end else begin
            // result transaction against the oldest prediction
            if (i_out_mon.valid && i_out_mon.ready) begin
                seen_display.led_on     = i_out_mon.led_on;
                seen_display.led_update = i_out_mon.led_update;
                seen_display.dac_level  = i_out_mon.dac_level;
                seen_display.dac_update = i_out_mon.dac_update;
                if (display_q.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none actual %0h",
                             $time, seen_display);
                    mismatches++;
                end else begin
                    want_display = display_q.pop_front();
                    check_field("led_on", want_display.led_on, seen_display.led_on);
                    check_field("led_update", 8'(want_display.led_update),
                                8'(seen_display.led_update));
                    check_field("dac_level", want_display.dac_level, seen_display.dac_level);
                    check_field("dac_update", 8'(want_display.dac_update),
                                8'(seen_display.dac_update));
                end
            end
            // input transaction
            if (i_in_mon.valid && i_in_mon.ready) begin
                seen_item.cmd          = i_in_mon.cmd;
                seen_item.data_page    = i_in_mon.data_page;
                seen_item.pdu_format   = i_in_mon.pdu_format;
                seen_item.pdu_specific = i_in_mon.pdu_specific;
                seen_item.wind_speed   = i_in_mon.wind_speed;
                seen_item.wind_angle   = i_in_mon.wind_angle;
                display_q.push_back(predict_display(seen_item));
            end
            // register write, unknown indexes dropped
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GROUP:   cfg_group   = i_cfg_data[GROUP_W-1:0];
                    REG_TIMEOUT: cfg_timeout = i_cfg_data[7:0];
                    REG_TICKS:   cfg_ticks   = i_cfg_data[7:0];
                    REG_TENTHS:  cfg_tenths  = i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
        o_pending_results <= display_q.size();
        o_mismatch_total  <= mismatches;
    end

endmodule

// ===== tb/wind_display_driver_tb.sv =====
// top of the wind display driver testbench: clock, reset, config writes and
// frame and tick stimulus with random back-pressure; gives the verdict
// depends on wdd_pkg, wdd_tb_pkg, both channel interfaces and the checker
module wind_display_driver_tb
    import wdd_pkg::*;
    import wdd_tb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF     = 4;
    localparam int unsigned DRAIN_LIMIT  = 50000;
    localparam int unsigned RUN_LIMIT_NS = 2000000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    wdd_in_if  in_bus();
    wdd_out_if out_bus();

    int unsigned        mismatch_total;
    int unsigned        pending_results;
    int unsigned        tx_idle_pct = 22;
    int unsigned        rx_idle_pct = 87;
    logic [GROUP_W-1:0] cur_group   = RST_GROUP;

    wind_display_driver dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    wind_display_driver_checker checker_inst (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_in_mon          (in_bus),
        .i_out_mon         (out_bus),
        .o_mismatch_total  (mismatch_total),
        .o_pending_results (pending_results)
    );

    always #(CLK_HALF) clk = ~clk;

    // receiver back-pressure
    initial begin
        out_bus.ready <= 1'b0;
        forever begin
            @(negedge clk);
            out_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // overall time limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("wind_display_driver regression: fail");
        $finish;
    end

    // one register write, the enable changes only at falling edges
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == REG_GROUP) begin
            cur_group = data[GROUP_W-1:0];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // a group number that some frame can match
    function automatic logic [GROUP_W-1:0] reachable_group();
        logic [7:0] pf;
        pf = 8'($urandom);
        return {1'($urandom), pf, (pf > PF_GROUP_MIN) ? 8'($urandom) : 8'h00};
    endfunction

    // frame for the current group, or one with a bit of its id flipped or a random id
    function automatic t_in_item make_frame(input bit hit);
        t_in_item           item;
        logic [GROUP_W-1:0] id;
        item.cmd        = CMD_FRAME;
        item.wind_speed = $urandom_range(0, 1) ? 16'($urandom_range(0, 2600)) : 16'($urandom);
        item.wind_angle = 16'($urandom);
        id = cur_group;
        if (cur_group[15:8] <= PF_GROUP_MIN) begin
            id[7:0] = 8'($urandom);
        end
        if (!hit) begin
            if ($urandom_range(0, 1)) begin
                id = id ^ (17'd1 << $urandom_range(0, GROUP_W - 1));
            end else begin
                id = 17'($urandom);
            end
        end
        {item.data_page, item.pdu_format, item.pdu_specific} = id;
        return item;
    endfunction

    // tick with junk in the unused fields
    function automatic t_in_item make_tick();
        t_in_item item;
        item     = t_in_item'({$urandom, $urandom});
        item.cmd = CMD_TICK;
        return item;
    endfunction

    // offer one transaction, entered and left at a falling edge
    task automatic send_item(input t_in_item item);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(negedge clk);
        end
        in_bus.valid        <= 1'b1;
        in_bus.cmd          <= item.cmd;
        in_bus.data_page    <= item.data_page;
        in_bus.pdu_format   <= item.pdu_format;
        in_bus.pdu_specific <= item.pdu_specific;
        in_bus.wind_speed   <= item.wind_speed;
        in_bus.wind_angle   <= item.wind_angle;
        do @(posedge clk); while (!in_bus.ready);
        @(negedge clk);
    endtask

    // mostly matching frames and ticks, some missed frames
    task automatic send_mix(input int unsigned count, input int unsigned tick_pct);
        repeat (count) begin
            if ($urandom_range(0, 99) < tick_pct) begin
                send_item(make_tick());
            end else begin
                send_item(make_frame($urandom_range(0, 99) < 75));
            end
        end
    endtask

    // stop offering and wait until every result is back or the wait limit runs out
    task automatic drain();
        int unsigned waited;
        waited = 0;
        in_bus.valid <= 1'b0;
        while (pending_results != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (4) @(negedge clk);
    endtask

    initial begin
        t_in_item item;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= REG_GROUP;
        cfg_data            <= '0;
        in_bus.valid        <= 1'b0;
        in_bus.cmd          <= CMD_TICK;
        in_bus.data_page    <= 1'b0;
        in_bus.pdu_format   <= 8'd0;
        in_bus.pdu_specific <= 8'd0;
        in_bus.wind_speed   <= 16'd0;
        in_bus.wind_angle   <= 16'd0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: every sector with a range of speeds, at reset settings
        for (int k = 0; k < 16; k++) begin
            item            = make_frame(1'b1);
            item.wind_angle = 16'(k * 3927);
            item.wind_speed = 16'(k * 170);
            send_item(item);
        end
        // saturation edge, sector boundary, largest values
        item = make_frame(1'b1);
        item.wind_speed = 16'd2478;
        item.wind_angle = 16'd1963;
        send_item(item);
        item.wind_speed = 16'd2479;
        item.wind_angle = 16'd1964;
        send_item(item);
        item.wind_speed = 16'hFFFF;
        item.wind_angle = 16'hFFFF;
        send_item(item);
        // frames that miss by page, format or extension
        item = make_frame(1'b1);
        item.data_page = ~item.data_page;
        send_item(item);
        item = make_frame(1'b1);
        item.pdu_format = item.pdu_format ^ 8'h01;
        send_item(item);
        item = make_frame(1'b1);
        item.pdu_specific = ~item.pdu_specific;
        send_item(item);
        send_item(make_tick());
        send_mix(150, 60);

        // fastest seconds, shortest nonzero timeout, group without extension
        drain();
        write_reg(REG_GROUP, 17'h00C00);
        write_reg(REG_TIMEOUT, 17'd1);
        write_reg(REG_TICKS, 17'd1);
        write_reg(REG_TENTHS, 17'd1);
        send_mix(200, 65);

        // largest settings
        drain();
        tx_idle_pct = 87;
        rx_idle_pct = 22;
        write_reg(REG_GROUP, 17'h1FFFF);
        write_reg(REG_TIMEOUT, 17'd255);
        write_reg(REG_TICKS, 17'd255);
        write_reg(REG_TENTHS, 17'd15);
        send_mix(150, 60);

        // zero written to dividers and timeout, bits above the register width
        // dropped, writes to unused indexes ignored
        drain();
        write_reg(REG_GROUP, 17'h00000);
        write_reg(REG_TIMEOUT, 17'h1FF00);
        write_reg(REG_TICKS, 17'h1FF00);
        write_reg(REG_TENTHS, 17'h1FFF0);
        write_reg(CFG_IDX_W'($urandom_range(4, 15)), 17'($urandom));
        send_mix(200, 60);

        // random small settings, no idling
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (5) begin
            drain();
            write_reg(REG_GROUP, reachable_group());
            write_reg(REG_TIMEOUT, 17'($urandom_range(1, 3)));
            write_reg(REG_TICKS, 17'($urandom_range(1, 4)));
            write_reg(REG_TENTHS, 17'($urandom_range(1, 3)));
            write_reg(CFG_IDX_W'($urandom_range(4, 15)), 17'($urandom));
            send_mix(70, 55);
        end

        drain();
        if (mismatch_total == 0 && pending_results == 0) begin
            $display("wind_display_driver regression: pass");
        end else begin
            $display("wind_display_driver regression: fail");
        end
        $finish;
    end

endmodule
